/* hw/rtl/spit_pkg.sv */
// ---------------------------------------------------------------------------
// Shape pair intersection test package
// Shape kind codes and test codes that the top level and the datapath share.
// ---------------------------------------------------------------------------
`default_nettype none

package spit_pkg;

	// Shape kind codes as they arrive on the input stream.
	localparam logic [1:0] KIND_SEG  = 2'd0;
	localparam logic [1:0] KIND_RECT = 2'd1;
	localparam logic [1:0] KIND_CIRC = 2'd2;

	// Pair test that the block selects for a transaction.
	typedef enum logic [2:0] {
		TEST_RR   = 3'd0,
		TEST_RC   = 3'd1,
		TEST_RS   = 3'd2,
		TEST_CC   = 3'd3,
		TEST_CS   = 3'd4,
		TEST_NONE = 3'd5
	} test_t;

	// Number of register stages in the datapath.
	localparam int NUM_STAGES = 7;

endpackage

`default_nettype wire

/* hw/rtl/spit_datapath.sv */
// ---------------------------------------------------------------------------
// Shape pair intersection datapath
// Seven-stage pipeline: ordering, differences, products, sums, partial
// products of the wide compare, their combination, and the final decision.
// ---------------------------------------------------------------------------
`default_nettype none

module spit_datapath #(
	parameter int W = 16
) (
	input  wire logic                        clk,
	input  wire logic [spit_pkg::NUM_STAGES-1:0] en,
	input  wire logic [1:0]                  kind_a,
	input  wire logic                        active_a,
	input  wire logic signed [W-1:0]         a_word [4],
	input  wire logic [1:0]                  kind_b,
	input  wire logic                        active_b,
	input  wire logic signed [W-1:0]         b_word [4],
	output logic                             hit,
	output spit_pkg::test_t                  test_used
);

	localparam int D  = W + 1;
	localparam int P  = 2 * D;
	localparam int S  = 2 * W + 4;
	localparam int MB = 2 * W + 1;
	localparam int L  = (MB + 1) / 2;
	localparam int H  = MB - L;

	function automatic logic signed [D-1:0] max3(logic signed [D-1:0] x,
	                                              logic signed [D-1:0] y);
		logic signed [D-1:0] m;
		m = (x > y) ? x : y;
		return (m > 0) ? m : '0;
	endfunction

	// ---------------- Stage 1: order the pair and pick the test ----------------
	logic                    swap;
	spit_pkg::test_t         code_c;
	logic [1:0]              kp, kq;
	logic signed [W-1:0]     pw_s1 [4];
	logic signed [W-1:0]     qw_s1 [4];
	spit_pkg::test_t         code_s1;
	logic                    act_s1;

	always_comb begin
		swap = (kind_b == spit_pkg::KIND_RECT && kind_a != spit_pkg::KIND_RECT) ||
		       (kind_b == spit_pkg::KIND_CIRC && kind_a == spit_pkg::KIND_SEG);
		kp = swap ? kind_b : kind_a;
		kq = swap ? kind_a : kind_b;
		code_c = spit_pkg::TEST_NONE;
		if (kind_a != 2'd3 && kind_b != 2'd3) begin
			unique case (kp)
				spit_pkg::KIND_RECT: begin
					unique case (kq)
						spit_pkg::KIND_RECT: code_c = spit_pkg::TEST_RR;
						spit_pkg::KIND_CIRC: code_c = spit_pkg::TEST_RC;
						default:             code_c = spit_pkg::TEST_RS;
					endcase
				end
				spit_pkg::KIND_CIRC: begin
					code_c = (kq == spit_pkg::KIND_CIRC) ? spit_pkg::TEST_CC
					                                      : spit_pkg::TEST_CS;
				end
				default: code_c = spit_pkg::TEST_NONE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 4; i++) begin
				pw_s1[i] <= swap ? b_word[i] : a_word[i];
				qw_s1[i] <= swap ? a_word[i] : b_word[i];
			end
			code_s1 <= code_c;
			act_s1  <= active_a & active_b;
		end
	end

	// ---------------- Stage 2: coordinate differences ----------------
	logic signed [D-1:0] dxrc, dyrc, cx_c, cy_c, rr_c, yx_c, yy_c;
	logic signed [D-1:0] exd_c, eyd_c, rx0_c, rx1_c, ry0_c, ry1_c;
	logic signed [D-1:0] cx_s2, cy_s2, rr_s2, yx_s2, yy_s2;
	logic signed [D-1:0] exd_s2, eyd_s2, dxa_s2, dya_s2;
	logic signed [D-1:0] rx0_s2, rx1_s2, ry0_s2, ry1_s2;
	logic signed [D-1:0] nx0_s2, nx1_s2, ny0_s2, ny1_s2;
	logic                xok_s2, yok_s2, rrhit_s2, act_s2;
	spit_pkg::test_t     code_s2;

	always_comb begin
		dxrc = max3(D'(pw_s1[0]) - D'(qw_s1[0]), D'(qw_s1[0]) - D'(pw_s1[2]));
		dyrc = max3(D'(pw_s1[1]) - D'(qw_s1[1]), D'(qw_s1[1]) - D'(pw_s1[3]));
		yx_c = D'(qw_s1[2]) - D'(qw_s1[0]);
		yy_c = D'(qw_s1[3]) - D'(qw_s1[1]);
		unique case (code_s1)
			spit_pkg::TEST_RC: begin
				cx_c = dxrc;
				cy_c = dyrc;
				rr_c = D'(qw_s1[2]);
			end
			spit_pkg::TEST_CC: begin
				cx_c = D'(pw_s1[0]) - D'(qw_s1[0]);
				cy_c = D'(pw_s1[1]) - D'(qw_s1[1]);
				rr_c = D'(pw_s1[2]) + D'(qw_s1[2]);
			end
			default: begin
				cx_c = D'(qw_s1[0]) - D'(pw_s1[0]);
				cy_c = D'(qw_s1[1]) - D'(pw_s1[1]);
				rr_c = D'(pw_s1[2]);
			end
		endcase
		exd_c = D'(qw_s1[2]) - D'(qw_s1[0]);
		eyd_c = D'(qw_s1[3]) - D'(qw_s1[1]);
		rx0_c = D'(pw_s1[0]) - D'(qw_s1[0]);
		rx1_c = D'(pw_s1[2]) - D'(qw_s1[0]);
		ry0_c = D'(pw_s1[1]) - D'(qw_s1[1]);
		ry1_c = D'(pw_s1[3]) - D'(qw_s1[1]);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cx_s2   <= cx_c;
			cy_s2   <= cy_c;
			rr_s2   <= rr_c;
			yx_s2   <= yx_c;
			yy_s2   <= yy_c;
			exd_s2  <= exd_c;
			eyd_s2  <= eyd_c;
			dxa_s2  <= exd_c[D-1] ? -exd_c : exd_c;
			dya_s2  <= eyd_c[D-1] ? -eyd_c : eyd_c;
			rx0_s2  <= rx0_c;
			rx1_s2  <= rx1_c;
			ry0_s2  <= ry0_c;
			ry1_s2  <= ry1_c;
			nx0_s2  <= exd_c[D-1] ? -rx0_c : rx0_c;
			nx1_s2  <= exd_c[D-1] ? -rx1_c : rx1_c;
			ny0_s2  <= eyd_c[D-1] ? -ry0_c : ry0_c;
			ny1_s2  <= eyd_c[D-1] ? -ry1_c : ry1_c;
			xok_s2  <= pw_s1[0] <= pw_s1[2];
			yok_s2  <= pw_s1[1] <= pw_s1[3];
			rrhit_s2 <= !(pw_s1[2] < qw_s1[0] || pw_s1[0] > qw_s1[2] ||
			              pw_s1[3] < qw_s1[1] || pw_s1[1] > qw_s1[3]);
			code_s2 <= code_s1;
			act_s2  <= act_s1;
		end
	end

	// ---------------- Stage 3: products ----------------
	logic signed [P-1:0] sqx_s3, sqy_s3, sqr_s3, syx_s3, syy_s3, hxx_s3, hxy_s3;
	logic signed [P-1:0] plx_s3, phx_s3, qx0_s3, qx1_s3;
	logic signed [P-1:0] ply_s3, phy_s3, qy0_s3, qy1_s3;
	logic                sx0_s3, sx1_s3, sy0_s3, sy1_s3, rrhit_s3, act_s3;
	spit_pkg::test_t     code_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sqx_s3 <= P'(cx_s2) * P'(cx_s2);
			sqy_s3 <= P'(cy_s2) * P'(cy_s2);
			sqr_s3 <= P'(rr_s2) * P'(rr_s2);
			syx_s3 <= P'(yx_s2) * P'(yx_s2);
			syy_s3 <= P'(yy_s2) * P'(yy_s2);
			hxx_s3 <= P'(cx_s2) * P'(yx_s2);
			hxy_s3 <= P'(cy_s2) * P'(yy_s2);
			plx_s3 <= P'(ry0_s2) * P'(dxa_s2);
			phx_s3 <= P'(ry1_s2) * P'(dxa_s2);
			qx0_s3 <= P'(nx0_s2) * P'(eyd_s2);
			qx1_s3 <= P'(nx1_s2) * P'(eyd_s2);
			ply_s3 <= P'(rx0_s2) * P'(dya_s2);
			phy_s3 <= P'(rx1_s2) * P'(dya_s2);
			qy0_s3 <= P'(ny0_s2) * P'(exd_s2);
			qy1_s3 <= P'(ny1_s2) * P'(exd_s2);
			// Crossing parameter must lie on the segment and the side must exist.
			sx0_s3 <= xok_s2 && dxa_s2 != 0 && !nx0_s2[D-1] && nx0_s2 <= dxa_s2;
			sx1_s3 <= xok_s2 && dxa_s2 != 0 && !nx1_s2[D-1] && nx1_s2 <= dxa_s2;
			sy0_s3 <= yok_s2 && dya_s2 != 0 && !ny0_s2[D-1] && ny0_s2 <= dya_s2;
			sy1_s3 <= yok_s2 && dya_s2 != 0 && !ny1_s2[D-1] && ny1_s2 <= dya_s2;
			rrhit_s3 <= rrhit_s2;
			code_s3  <= code_s2;
			act_s3   <= act_s2;
		end
	end

	// ---------------- Stage 4: sums and side compares ----------------
	logic signed [S-1:0] sumd_c;
	logic signed [S-1:0] a_s4, h_s4, f0_s4;
	logic                chit_s4, rshit_s4, rrhit_s4, act_s4;
	spit_pkg::test_t     code_s4;

	assign sumd_c = S'(sqx_s3) + S'(sqy_s3);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			a_s4    <= S'(syx_s3) + S'(syy_s3);
			h_s4    <= S'(hxx_s3) + S'(hxy_s3);
			f0_s4   <= sumd_c - S'(sqr_s3);
			chit_s4 <= sumd_c <= S'(sqr_s3);
			rshit_s4 <= (sx0_s3 && plx_s3 <= qx0_s3 && qx0_s3 <= phx_s3) ||
			            (sx1_s3 && plx_s3 <= qx1_s3 && qx1_s3 <= phx_s3) ||
			            (sy0_s3 && ply_s3 <= qy0_s3 && qy0_s3 <= phy_s3) ||
			            (sy1_s3 && ply_s3 <= qy1_s3 && qy1_s3 <= phy_s3);
			rrhit_s4 <= rrhit_s3;
			code_s4  <= code_s3;
			act_s4   <= act_s3;
		end
	end

	// ---------------- Stage 5: root test and partial products ----------------
	logic signed [S-1:0] f1_c, nh_c;
	logic [MB-1:0]       mh_c, ma_c, mf_c;
	logic                fix_c, wide_c;
	logic [2*L-1:0]      hll_s5, all_s5;
	logic [L+H-1:0]      hlh_s5, alh_s5, ahl_s5;
	logic [2*H-1:0]      hhh_s5, ahh_s5;
	logic                fix_s5, wide_s5, chit_s5, rshit_s5, rrhit_s5, act_s5;
	spit_pkg::test_t     code_s5;

	always_comb begin
		f1_c = a_s4 + (h_s4 <<< 1) + f0_s4;
		nh_c = -h_s4;
		mh_c = nh_c[MB-1:0];
		ma_c = a_s4[MB-1:0];
		mf_c = f0_s4[MB-1:0];
		fix_c  = 1'b0;
		wide_c = 1'b0;
		// Both ends outside needs the vertex in range and a wide compare.
		priority if (a_s4 == 0)                 fix_c = 1'b0;
		else if (f0_s4 == 0 || f1_c == 0)       fix_c = 1'b1;
		else if (f0_s4[S-1] != f1_c[S-1])       fix_c = 1'b1;
		else if (f0_s4[S-1])                    fix_c = 1'b0;
		else if (h_s4 > 0 || nh_c > a_s4)       fix_c = 1'b0;
		else                                    wide_c = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			hll_s5 <= (2*L)'(mh_c[L-1:0]) * (2*L)'(mh_c[L-1:0]);
			hlh_s5 <= (L+H)'(mh_c[L-1:0]) * (L+H)'(mh_c[MB-1:L]);
			hhh_s5 <= (2*H)'(mh_c[MB-1:L]) * (2*H)'(mh_c[MB-1:L]);
			all_s5 <= (2*L)'(ma_c[L-1:0]) * (2*L)'(mf_c[L-1:0]);
			alh_s5 <= (L+H)'(ma_c[L-1:0]) * (L+H)'(mf_c[MB-1:L]);
			ahl_s5 <= (L+H)'(ma_c[MB-1:L]) * (L+H)'(mf_c[L-1:0]);
			ahh_s5 <= (2*H)'(ma_c[MB-1:L]) * (2*H)'(mf_c[MB-1:L]);
			fix_s5   <= fix_c;
			wide_s5  <= wide_c;
			chit_s5  <= chit_s4;
			rshit_s5 <= rshit_s4;
			rrhit_s5 <= rrhit_s4;
			code_s5  <= code_s4;
			act_s5   <= act_s4;
		end
	end

	// ---------------- Stage 6: combine partial products ----------------
	logic [2*MB-1:0] hsq_s6, afp_s6;
	logic            fix_s6, wide_s6, chit_s6, rshit_s6, rrhit_s6, act_s6;
	spit_pkg::test_t code_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			hsq_s6 <= ((2*MB)'(hhh_s5) << (2*L)) + ((2*MB)'(hlh_s5) << (L+1)) +
			          (2*MB)'(hll_s5);
			afp_s6 <= ((2*MB)'(ahh_s5) << (2*L)) +
			          (((2*MB)'(alh_s5) + (2*MB)'(ahl_s5)) << L) + (2*MB)'(all_s5);
			fix_s6   <= fix_s5;
			wide_s6  <= wide_s5;
			chit_s6  <= chit_s5;
			rshit_s6 <= rshit_s5;
			rrhit_s6 <= rrhit_s5;
			code_s6  <= code_s5;
			act_s6   <= act_s5;
		end
	end

	// ---------------- Stage 7: final decision ----------------
	logic cshit_c, hit_c;

	always_comb begin
		cshit_c = wide_s6 ? (hsq_s6 >= afp_s6) : fix_s6;
		unique case (code_s6)
			spit_pkg::TEST_RR: hit_c = rrhit_s6;
			spit_pkg::TEST_RC: hit_c = chit_s6;
			spit_pkg::TEST_RS: hit_c = rshit_s6;
			spit_pkg::TEST_CC: hit_c = chit_s6;
			spit_pkg::TEST_CS: hit_c = cshit_c;
			default:           hit_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			hit       <= act_s6 & hit_c;
			test_used <= code_s6;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/shape_pair_intersection_test.sv */
// Throughput: one transaction per cycle while m_tready is high; seven register
// stages, each with its own valid bit, and a stage takes new data whenever it is
// empty or its successor moves.
// The circle-segment compare is split into partial products over two stages.
// Reset clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
// Shape pair intersection test
// Streams pairs of 2D shapes and reports whether they intersect.
// ---------------------------------------------------------------------------
`default_nettype none

module shape_pair_intersection_test #(
	parameter int COORD_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// active_a, a_word0..3, active_b, b_word0..3, zero fill
	input  wire logic [((2 + 8 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// kind_a, kind_b
	input  wire logic [3:0] s_tuser,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// hit, test_used, zero fill
	output logic [7:0] m_tdata
);

	localparam int W  = COORD_BITS;
	localparam int NS = spit_pkg::NUM_STAGES;
	localparam int BB = 1 + 4 * W;

	logic [NS-1:0]       valid_q;
	logic [NS-1:0]       rdy;
	logic [NS-1:0]       vin;
	logic signed [W-1:0] a_word [4];
	logic signed [W-1:0] b_word [4];
	logic                hit;
	spit_pkg::test_t     test_used;

	// Unpack the shape words.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a_word[i] = s_tdata[1 + i * W +: W];
			b_word[i] = s_tdata[BB + 1 + i * W +: W];
		end
	end

	// Per-stage ready: a stage moves when it is empty or the next one moves.
	always_comb begin
		rdy[NS-1] = !valid_q[NS-1] || m_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
		vin = {valid_q[NS-2:0], s_tvalid};
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= vin[k];
				end
			end
		end
	end

	spit_datapath #(
		.W(W)
	) u_datapath (
		.clk       (clk),
		.en        (rdy),
		.kind_a    (s_tuser[1:0]),
		.active_a  (s_tdata[0]),
		.a_word    (a_word),
		.kind_b    (s_tuser[3:2]),
		.active_b  (s_tdata[BB]),
		.b_word    (b_word),
		.hit       (hit),
		.test_used (test_used)
	);

	// Output side.
	assign s_tready = rdy[0];
	assign m_tvalid = valid_q[NS-1];
	assign m_tdata  = {4'b0000, test_used, hit};

endmodule

`default_nettype wire
